### design/decimal_line_to_dac_setpoint_core_defines.svh
// Assertion macros shared by the decimal line to DAC setpoint design.
`ifndef DECIMAL_LINE_TO_DAC_SETPOINT_CORE_DEFINES_SVH
`define DECIMAL_LINE_TO_DAC_SETPOINT_CORE_DEFINES_SVH

// Plain property checked on every edge outside reset.
`define DLS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication checked outside reset.
`define DLS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/dls_pkg.sv
// Types and constants for the decimal line to DAC setpoint design.
package dls_pkg;

  localparam logic [1:0] CMD_BYTE = 2'd0;
  localparam logic [1:0] CMD_TICK = 2'd1;
  localparam logic [1:0] CMD_LINK = 2'd2;

  localparam logic [1:0] KIND_SET  = 2'd0;
  localparam logic [1:0] KIND_CONN = 2'd1;
  localparam logic [1:0] KIND_DISC = 2'd2;

  localparam logic [7:0] CHAR_CR   = 8'd13;
  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;

  localparam logic [8:0]  VALUE_SAT     = 9'd256;
  localparam logic [7:0]  VALUE_MAX     = 8'd255;
  localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] data_byte;
    logic       link_up;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [11:0] dac_code;
    logic [7:0]  set_value;
  } out_item_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } step_res_t;

endpackage

### design/dls_scale.sv
// Scales a 0..255 setpoint to a 12-bit code, value*4095/255.
module dls_scale (
  input  logic [7:0]  value,
  output logic [11:0] code
);

  // value*4095/255 = 16*value + floor(value/17); value/17 via 241/4096.
  localparam logic [15:0] RECIP_17 = 16'd241;

  logic [15:0] prod;

  assign prod = 16'(value) * RECIP_17;
  assign code = {value, 4'b0000} + 12'(prod[15:12]);

endmodule

### design/dls_ctrl.sv
// Link state, idle timer, decimal line accumulator and result formation.
`include "decimal_line_to_dac_setpoint_core_defines.svh"

module dls_ctrl #(
  parameter int LINE_CAPACITY = 1023
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  dls_pkg::in_item_t   item,
  input  logic [15:0]         timeout,
  output dls_pkg::step_res_t  res
);

  localparam int CNT_W = $clog2(LINE_CAPACITY + 1);

  logic             conn_r, conn_nxt;
  logic [15:0]      idle_r, idle_nxt;
  logic [8:0]       acc_r, acc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [16:0] tick_next;
  logic [11:0] acc_mul;
  logic [3:0]  digit;
  logic        is_digit;
  logic [7:0]  clamp_val;
  logic [7:0]  res_val;
  logic [1:0]  res_kind;
  logic        res_valid;
  logic [11:0] scaled;

  assign tick_next = 17'(idle_r) + 17'd1;
  assign digit     = 4'(item.data_byte - dls_pkg::CHAR_ZERO);
  assign is_digit  = (item.data_byte >= dls_pkg::CHAR_ZERO) &&
                     (item.data_byte <= dls_pkg::CHAR_NINE);
  assign acc_mul   = {acc_r, 3'b000} + {2'b00, acc_r, 1'b0} + 12'(digit);
  assign clamp_val = (acc_r > 9'(dls_pkg::VALUE_MAX)) ? dls_pkg::VALUE_MAX : acc_r[7:0];

  always_comb begin
    conn_nxt  = conn_r;
    idle_nxt  = idle_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    res_valid = 1'b0;
    res_kind  = dls_pkg::KIND_SET;
    res_val   = 8'd0;
    case (item.command)
      dls_pkg::CMD_BYTE: begin
        if (conn_r) begin
          idle_nxt = 16'd0;
          if (item.data_byte == dls_pkg::CHAR_CR) begin
            if (cnt_r != '0) begin
              res_valid = 1'b1;
              res_val   = clamp_val;
            end
            acc_nxt = 9'd0;
            cnt_nxt = '0;
          end else if (is_digit && (cnt_r < CNT_W'(LINE_CAPACITY))) begin
            acc_nxt = (acc_mul > 12'(dls_pkg::VALUE_SAT)) ? dls_pkg::VALUE_SAT : acc_mul[8:0];
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
      end
      dls_pkg::CMD_TICK: begin
        if (conn_r) begin
          if (tick_next > 17'(timeout)) begin
            conn_nxt  = 1'b0;
            idle_nxt  = 16'd0;
            res_valid = 1'b1;
            res_kind  = dls_pkg::KIND_DISC;
          end else begin
            idle_nxt = tick_next[15:0];
          end
        end
      end
      dls_pkg::CMD_LINK: begin
        if (item.link_up && !conn_r) begin
          conn_nxt  = 1'b1;
          idle_nxt  = 16'd0;
          res_valid = 1'b1;
          res_kind  = dls_pkg::KIND_CONN;
        end else if (!item.link_up && conn_r) begin
          conn_nxt  = 1'b0;
          idle_nxt  = 16'd0;
          res_valid = 1'b1;
          res_kind  = dls_pkg::KIND_DISC;
        end
      end
      default: begin
      end
    endcase
  end

  dls_scale u_scale (
    .value (res_val),
    .code  (scaled)
  );

  assign res.valid           = res_valid;
  assign res.item.event_kind = res_kind;
  assign res.item.dac_code   = scaled;
  assign res.item.set_value  = res_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_r <= 1'b0;
      idle_r <= 16'd0;
      acc_r  <= 9'd0;
      cnt_r  <= '0;
    end else if (fire) begin
      conn_r <= conn_nxt;
      idle_r <= idle_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  `DLS_ASSERT(a_acc_range, clk, rst_n, acc_r <= dls_pkg::VALUE_SAT, "accumulator above saturation")
  `DLS_ASSERT(a_cnt_range, clk, rst_n, cnt_r <= CNT_W'(LINE_CAPACITY), "digit count past capacity")
  `DLS_ASSERT_NEXT(a_conn_sets, clk, rst_n, fire && res.valid && (res.item.event_kind == dls_pkg::KIND_CONN), conn_r && (idle_r == 16'd0), "connect notice did not set link")
  `DLS_ASSERT_NEXT(a_disc_clears, clk, rst_n, fire && res.valid && (res.item.event_kind == dls_pkg::KIND_DISC), !conn_r && (idle_r == 16'd0), "disconnect did not clear link")

endmodule

### design/decimal_line_to_dac_setpoint_core.sv
// Top level: input register, control logic and result register.
//
// Decimal line to DAC setpoint core. Each input item is a received byte, a
// millisecond tick or a link status report; at most one result item follows
// each. The block takes one item per clock unless a held result waits on
// out_ready; an accepted item is held in the input register, then the decode,
// accumulate and scale logic writes the result register. A stalled result
// register holds the input register, and the input register still takes a
// new item in the cycle its current item moves on. The idle timeout is to be
// written through cfg_data only while the block is idle; the block itself does
// not enforce this. cfg_ready is always high.
module decimal_line_to_dac_setpoint_core #(
  parameter int LINE_CAPACITY = 1023
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  dls_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output dls_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);

  logic               in_valid_r;
  dls_pkg::in_item_t  in_r;
  logic               out_valid_r;
  dls_pkg::out_item_t out_r;
  logic [15:0]        timeout_r;
  logic               proc_fire;
  dls_pkg::step_res_t res;

  assign proc_fire = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || proc_fire;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= dls_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  dls_ctrl #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (proc_fire),
    .item    (in_r),
    .timeout (timeout_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire) begin
      out_valid_r <= res.valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_r <= res.item;
    end
  end

endmodule

### sim/tb_decimal_line_to_dac_setpoint_core.sv
// Self-checking testbench for the decimal line to DAC setpoint core.
module tb_decimal_line_to_dac_setpoint_core;

  localparam logic [1:0] CMD_NONE = 2'd3;   // unused command, must be ignored
  localparam int DAC_FULL = 4095;
  localparam int LINE_CAP = 1023;
  localparam int LONG_HOLD = 300;
  localparam int unsigned RUN_LIMIT = 100_000_000;

  typedef enum {CHK_MODEL, CHK_NONE, CHK_RESULT} chk_mode_e;

  typedef struct {
    dls_pkg::in_item_t  ev;
    chk_mode_e          mode;
    dls_pkg::out_item_t want;
  } drow_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  dls_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  dls_pkg::out_item_t out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [15:0]        cfg_data = '0;

  // predictor state
  logic        link_on = 1'b0;
  logic [15:0] idle_ms = '0;
  logic [8:0]  line_val = '0;
  logic [9:0]  line_digits = '0;
  logic [15:0] idle_limit = dls_pkg::TIMEOUT_RESET;

  dls_pkg::out_item_t pending[$];
  int gap_max = 7;
  int stall_max = 7;
  int hold_asks = 0;
  int n_err = 0;
  int n_items = 0;
  int n_set = 0;
  int n_conn = 0;
  int n_disc = 0;

  decimal_line_to_dac_setpoint_core #(
    .LINE_CAPACITY(LINE_CAP)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic dls_pkg::in_item_t ev_of(logic [1:0] cmd, logic [7:0] b, logic up);
    dls_pkg::in_item_t ev;
    ev.command = cmd;
    ev.data_byte = b;
    ev.link_up = up;
    return ev;
  endfunction

  function automatic drow_t mk_row(logic [1:0] cmd, logic [7:0] b, logic up,
                                   chk_mode_e mode = CHK_MODEL,
                                   logic [1:0] kind = dls_pkg::KIND_SET,
                                   logic [11:0] code = '0, logic [7:0] val = '0);
    drow_t r;
    r.ev = ev_of(cmd, b, up);
    r.mode = mode;
    r.want.event_kind = kind;
    r.want.dac_code = code;
    r.want.set_value = val;
    return r;
  endfunction

  // Advances the line/link state by one item; returns 1 when a result is due.
  function automatic bit predict_setpoint(input dls_pkg::in_item_t it,
                                          output dls_pkg::out_item_t res);
    logic [16:0] next_idle;
    logic [7:0]  applied;
    int          grown;
    int          scaled;
    bit          hit;
    hit = 1'b0;
    res = '0;
    if (it.command == dls_pkg::CMD_BYTE && link_on) begin
      idle_ms = '0;
      if (it.data_byte == dls_pkg::CHAR_CR) begin
        if (line_digits != '0) begin
          applied = (line_val > dls_pkg::VALUE_MAX) ? dls_pkg::VALUE_MAX : line_val[7:0];
          scaled = int'(applied) * DAC_FULL / int'(dls_pkg::VALUE_MAX);
          res.event_kind = dls_pkg::KIND_SET;
          res.dac_code = 12'(scaled);
          res.set_value = applied;
          hit = 1'b1;
        end
        line_val = '0;
        line_digits = '0;
      end else if (it.data_byte >= dls_pkg::CHAR_ZERO && it.data_byte <= dls_pkg::CHAR_NINE &&
                   line_digits < 10'(LINE_CAP)) begin
        grown = int'(line_val) * 10 + int'(it.data_byte - dls_pkg::CHAR_ZERO);
        line_val = (grown > int'(dls_pkg::VALUE_SAT)) ? dls_pkg::VALUE_SAT : 9'(grown);
        line_digits = line_digits + 10'd1;
      end
    end else if (it.command == dls_pkg::CMD_TICK && link_on) begin
      next_idle = {1'b0, idle_ms} + 17'd1;
      if (next_idle > {1'b0, idle_limit}) begin
        link_on = 1'b0;
        idle_ms = '0;
        res.event_kind = dls_pkg::KIND_DISC;
        hit = 1'b1;
      end else begin
        idle_ms = next_idle[15:0];
      end
    end else if (it.command == dls_pkg::CMD_LINK && it.link_up != link_on) begin
      link_on = it.link_up;
      idle_ms = '0;
      res.event_kind = it.link_up ? dls_pkg::KIND_CONN : dls_pkg::KIND_DISC;
      hit = 1'b1;
    end
    return hit;
  endfunction

  // Mostly well-formed traffic while the link is up, noise while it is down.
  function automatic dls_pkg::in_item_t draw_event();
    dls_pkg::in_item_t ev;
    int r;
    ev = ev_of(dls_pkg::CMD_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    r = $urandom_range(0, 99);
    if (!link_on) begin
      if (r < 60) begin
        ev.command = dls_pkg::CMD_LINK;
        ev.link_up = 1'b1;
      end else begin
        ev.command = 2'($urandom_range(0, 3));
      end
    end else if (r < 40) begin
      ev.data_byte = dls_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    end else if (r < 55) begin
      ev.data_byte = dls_pkg::CHAR_CR;
    end else if (r < 75) begin
      ev.command = dls_pkg::CMD_TICK;
    end else if (r < 81) begin
      ev.command = dls_pkg::CMD_LINK;
    end else if (r < 85) begin
      ev.command = CMD_NONE;
    end
    return ev;
  endfunction

  task automatic offer(input dls_pkg::in_item_t it, input chk_mode_e mode = CHK_MODEL,
                       input dls_pkg::out_item_t typed = '0);
    int                 gap;
    bit                 hit;
    dls_pkg::out_item_t res;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    hit = predict_setpoint(it, res);
    n_items++;
    if (mode == CHK_RESULT) begin
      res = typed;
      hit = 1'b1;
    end else if (mode == CHK_NONE) begin
      hit = 1'b0;
    end
    if (hit) begin
      pending.push_back(res);
      case (res.event_kind)
        dls_pkg::KIND_SET:  n_set++;
        dls_pkg::KIND_CONN: n_conn++;
        default:            n_disc++;
      endcase
    end
  endtask

  // Drop valid, wait for every expected item, then give the pipe time to empty.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_idle_limit(input logic [15:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    idle_limit = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      // occasional stretches with no idling on either side
      if (i % 64 == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          gap_max = 0;
          stall_max = 0;
        end else begin
          gap_max = 7;
          stall_max = 7;
        end
      end
      offer(draw_event());
    end
    settle();
  endtask

  // receiver: random stall after each item, plus a long hold-off on request
  always @(posedge clk) begin
    static int hold_left = 0;
    static int hold_done = 0;
    logic rdy;
    if (hold_asks != hold_done) begin
      hold_done = hold_asks;
      hold_left = LONG_HOLD;
    end else if (out_valid && out_ready) begin
      hold_left = $urandom_range(0, stall_max);
    end
    if (hold_left > 0) begin
      rdy = 1'b0;
      hold_left--;
    end else begin
      rdy = 1'b1;
    end
    out_ready <= rdy;
  end

  always @(posedge clk) begin
    dls_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending.size() == 0) begin
        $error("unexpected item: kind %0d code %0d value %0d",
               out_data.event_kind, out_data.dac_code, out_data.set_value);
        n_err++;
      end else begin
        want = pending.pop_front();
        if (out_data.event_kind !== want.event_kind) begin
          $error("event_kind: expected %0d, got %0d", want.event_kind, out_data.event_kind);
          n_err++;
        end
        if (out_data.dac_code !== want.dac_code) begin
          $error("dac_code: expected %0d, got %0d", want.dac_code, out_data.dac_code);
          n_err++;
        end
        if (out_data.set_value !== want.set_value) begin
          $error("set_value: expected %0d, got %0d", want.set_value, out_data.set_value);
          n_err++;
        end
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout: %0d items still expected", pending.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    drow_t dir_rows[$];
    dir_rows = {
      // link down: everything ignored
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_ZERO + 8'd5, 1'b0, CHK_NONE),
      mk_row(dls_pkg::CMD_TICK, 8'd0, 1'b0, CHK_NONE),
      mk_row(dls_pkg::CMD_LINK, 8'd0, 1'b0, CHK_NONE),
      mk_row(CMD_NONE, 8'hff, 1'b1, CHK_NONE),
      mk_row(dls_pkg::CMD_LINK, 8'd0, 1'b1, CHK_RESULT, dls_pkg::KIND_CONN),
      mk_row(dls_pkg::CMD_LINK, 8'd0, 1'b1, CHK_NONE),
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_CR, 1'b0, CHK_NONE),
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_ZERO, 1'b0),
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_CR, 1'b0, CHK_RESULT, dls_pkg::KIND_SET,
             12'd0, 8'd0),
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_ZERO + 8'd2, 1'b0),
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_ZERO + 8'd5, 1'b0),
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_ZERO + 8'd5, 1'b0),
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_CR, 1'b1, CHK_RESULT, dls_pkg::KIND_SET,
             12'd4095, 8'd255),
      // 999 saturates and is clamped to full scale
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_NINE, 1'b0),
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_NINE, 1'b0),
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_NINE, 1'b0),
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_CR, 1'b0, CHK_RESULT, dls_pkg::KIND_SET,
             12'd4095, 8'd255),
      // bytes just outside the digit range, and the byte extremes
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_ZERO - 8'd1, 1'b0),
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_NINE + 8'd1, 1'b0),
      mk_row(dls_pkg::CMD_BYTE, 8'hff, 1'b1),
      mk_row(dls_pkg::CMD_BYTE, 8'h00, 1'b0),
      // partial line survives a reconnect
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_ZERO + 8'd7, 1'b0),
      mk_row(dls_pkg::CMD_LINK, 8'd0, 1'b0, CHK_RESULT, dls_pkg::KIND_DISC),
      mk_row(dls_pkg::CMD_LINK, 8'd0, 1'b1, CHK_RESULT, dls_pkg::KIND_CONN),
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_ZERO + 8'd3, 1'b0),
      mk_row(dls_pkg::CMD_BYTE, dls_pkg::CHAR_CR, 1'b0)
    };

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) offer(dir_rows[i].ev, dir_rows[i].mode, dir_rows[i].want);
    settle();

    // traffic under the timeout left from reset
    run_random(150);

    // shortest timeout; first fill the block while the receiver holds off
    set_idle_limit(16'd1);
    gap_max = 0;
    stall_max = 0;
    hold_asks++;
    for (int i = 0; i < 40; i++) begin
      offer(ev_of(dls_pkg::CMD_LINK, 8'($urandom_range(0, 255)), ~link_on));
    end
    settle();
    run_random(150);

    set_idle_limit(16'd2);
    run_random(150);

    set_idle_limit(16'($urandom_range(3, 40)));
    run_random(150);

    // widest timeout; digits past the line capacity are dropped
    set_idle_limit(16'hffff);
    gap_max = 0;
    stall_max = 0;
    if (!link_on) offer(ev_of(dls_pkg::CMD_LINK, 8'd0, 1'b1));
    offer(ev_of(dls_pkg::CMD_BYTE, dls_pkg::CHAR_CR, 1'b0));
    repeat (LINE_CAP + 2) begin
      offer(ev_of(dls_pkg::CMD_BYTE, dls_pkg::CHAR_ZERO, 1'($urandom_range(0, 1))));
    end
    offer(ev_of(dls_pkg::CMD_BYTE, dls_pkg::CHAR_ZERO + 8'd7, 1'b0));
    offer(ev_of(dls_pkg::CMD_BYTE, dls_pkg::CHAR_CR, 1'b0));
    offer(ev_of(dls_pkg::CMD_BYTE, dls_pkg::CHAR_ZERO + 8'd5, 1'b0));
    offer(ev_of(dls_pkg::CMD_BYTE, dls_pkg::CHAR_CR, 1'b0));
    settle();

    set_idle_limit(16'($urandom_range(100, 600)));
    run_random(50);

    $display("%0d items driven: %0d setpoints, %0d connects, %0d disconnects checked",
             n_items, n_set, n_conn, n_disc);
    $display("ran short and long idle timeouts, line overflow, reconnects and a long stall");
    if (n_err == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
